[rtl/etp_pkg.sv]
// ----------------------------------------------------------------------------
// etp_pkg: shared types and constants of the exclusive time profiler
// trace event and result words, error codes, control structs between modules
// ----------------------------------------------------------------------------
package etp_pkg;

   localparam int ID_W    = 8;
   localparam int TIME_W  = 32;
   localparam int LAST_W  = TIME_W + 1;
   localparam int DEPTH_W = 7;
   localparam int ERR_W   = 2;
   localparam int ID_SPAN = 1 << ID_W;

   localparam logic [TIME_W-1:0] TOTAL_MAX = '1;

   localparam logic KIND_START = 1'b0;
   localparam logic KIND_END   = 1'b1;

   localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
   localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
   localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;
   localparam logic [ERR_W-1:0] ERR_BACK  = 2'd3;

   typedef struct packed {
      logic              kind;
      logic [ID_W-1:0]   func_id;
      logic [TIME_W-1:0] timestamp;
   } req_word_type;

   typedef struct packed {
      logic               credited_valid;
      logic [ID_W-1:0]    credited_func;
      logic [TIME_W-1:0]  credited_amount;
      logic [TIME_W-1:0]  new_total;
      logic [DEPTH_W-1:0] depth_after;
      logic [ERR_W-1:0]   error_code;
   } rsp_word_type;

   typedef struct packed {
      logic push;
      logic pop;
   } stack_op_type;

   typedef struct packed {
      logic empty;
      logic full;
   } stack_status_type;

   typedef struct packed {
      logic              push;
      logic              pop;
      logic              credit;
      logic [LAST_W-1:0] new_last;
      logic [TIME_W-1:0] new_total;
   } decision_type;

endpackage

[rtl/etp_stack.sv]
// ----------------------------------------------------------------------------
// etp_stack: call stack of active function ids
// top entry in a register, the one below prefetched from the memory each cycle
// ----------------------------------------------------------------------------
module etp_stack #(
   parameter int STACK_DEPTH = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  etp_pkg::stack_op_type        ops,
   input  logic [etp_pkg::ID_W-1:0]     push_id,
   output etp_pkg::stack_status_type    status,
   output logic [etp_pkg::ID_W-1:0]     top_id,
   output logic [etp_pkg::ID_W-1:0]     top_next,
   output logic [$clog2(STACK_DEPTH+1)-1:0] depth_next
);

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   logic [etp_pkg::ID_W-1:0] mem [STACK_DEPTH];

   logic [CW-1:0]            count_ff, count_in;
   logic [etp_pkg::ID_W-1:0] top_ff, top_in;
   logic [etp_pkg::ID_W-1:0] below_ff;
   logic [CW-1:0]            count_dec, count_sub2;
   logic [SW-1:0]            wr_addr, rd_addr;
   logic                     wr_en;

   always_comb begin
      count_in = count_ff;
      top_in   = top_ff;
      if (ops.push) begin
         count_in = count_ff + CW'(1);
         top_in   = push_id;
      end else if (ops.pop) begin
         count_in = count_ff - CW'(1);
         top_in   = below_ff;
      end
   end

   // old top moves into the memory on a push
   assign count_dec  = count_ff - CW'(1);
   assign wr_addr    = count_dec[SW-1:0];
   assign wr_en      = ops.push && (count_ff != '0);
   // entry just below the next top
   assign count_sub2 = count_in - CW'(2);
   assign rd_addr    = count_sub2[SW-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= top_ff;
      end
      if (wr_en && (wr_addr == rd_addr)) begin
         below_ff <= top_ff;
      end else begin
         below_ff <= mem[rd_addr];
      end
      top_ff <= top_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff >= CW'(STACK_DEPTH));
   assign top_id       = top_ff;
   assign top_next     = top_in;
   assign depth_next   = count_in;

endmodule

[rtl/etp_totals.sv]
// ----------------------------------------------------------------------------
// etp_totals: per-function exclusive time table
// cleared by a sweep after reset; total of the next top prefetched each cycle
// ----------------------------------------------------------------------------
module etp_totals #(
   parameter int NUM_FUNCS = 256
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        wr_en,
   input  logic [etp_pkg::ID_W-1:0]    wr_id,
   input  logic [etp_pkg::TIME_W-1:0]  wr_data,
   input  logic [etp_pkg::ID_W-1:0]    rd_id,
   output logic [etp_pkg::TIME_W-1:0]  rd_total,
   output logic                        clearing
);

   localparam int FW = (NUM_FUNCS > 1) ? $clog2(NUM_FUNCS) : 1;

   logic [etp_pkg::TIME_W-1:0] mem [NUM_FUNCS];
   logic [FW-1:0]              idx_lut [etp_pkg::ID_SPAN];

   logic [FW-1:0]              clr_addr_ff;
   logic                       clr_busy_ff;
   logic [FW-1:0]              mem_wr_addr, mem_rd_addr;
   logic                       mem_wr_en;
   logic [etp_pkg::TIME_W-1:0] mem_wr_data;
   logic [etp_pkg::TIME_W-1:0] rd_total_ff;

   // function id to table row, id modulo the table size
   for (genvar i = 0; i < etp_pkg::ID_SPAN; i++) begin : g_idx
      assign idx_lut[i] = FW'(i % NUM_FUNCS);
   end

   assign mem_wr_en   = clr_busy_ff || wr_en;
   assign mem_wr_addr = clr_busy_ff ? clr_addr_ff : idx_lut[wr_id];
   assign mem_wr_data = clr_busy_ff ? '0 : wr_data;
   assign mem_rd_addr = idx_lut[rd_id];

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         mem[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_wr_en && (mem_wr_addr == mem_rd_addr)) begin
         rd_total_ff <= mem_wr_data;
      end else begin
         rd_total_ff <= mem[mem_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + FW'(1);
         if (clr_addr_ff == FW'(NUM_FUNCS - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   assign rd_total = rd_total_ff;
   assign clearing = clr_busy_ff;

endmodule

[rtl/etp_eval.sv]
// ----------------------------------------------------------------------------
// etp_eval: event evaluation
// checks one trace event, works out the credit and the saturated new total
// ----------------------------------------------------------------------------
module etp_eval (
   input  etp_pkg::req_word_type       req,
   input  etp_pkg::stack_status_type   status,
   input  logic [etp_pkg::ID_W-1:0]    top_id,
   input  logic [etp_pkg::TIME_W-1:0]  cur_total,
   input  logic [etp_pkg::LAST_W-1:0]  last_time,
   output etp_pkg::decision_type       dec,
   output etp_pkg::rsp_word_type       rsp
);

   logic [etp_pkg::LAST_W-1:0] ts_ext;
   logic [etp_pkg::LAST_W-1:0] span;
   logic [etp_pkg::TIME_W-1:0] amount;
   logic [etp_pkg::LAST_W-1:0] sum;
   logic                       back;
   logic [etp_pkg::ERR_W-1:0]  err;

   assign ts_ext = {1'b0, req.timestamp};
   assign back   = (ts_ext < last_time);

   always_comb begin
      dec      = '0;
      err      = etp_pkg::ERR_NONE;
      span     = '0;
      amount   = '0;
      if (req.kind == etp_pkg::KIND_START) begin
         if (status.full) begin
            err = etp_pkg::ERR_FULL;
         end else if (back) begin
            err = etp_pkg::ERR_BACK;
         end else begin
            dec.push     = 1'b1;
            dec.credit   = !status.empty;
            dec.new_last = ts_ext;
            span         = ts_ext - last_time;
            amount       = span[etp_pkg::TIME_W-1:0];
         end
      end else begin
         if (status.empty) begin
            err = etp_pkg::ERR_EMPTY;
         end else if (back) begin
            err = etp_pkg::ERR_BACK;
         end else begin
            dec.pop      = 1'b1;
            dec.credit   = 1'b1;
            dec.new_last = ts_ext + etp_pkg::LAST_W'(1);
            span         = ts_ext - last_time + etp_pkg::LAST_W'(1);
            amount       = span[etp_pkg::TIME_W] ? etp_pkg::TOTAL_MAX
                                                 : span[etp_pkg::TIME_W-1:0];
         end
      end
      sum           = {1'b0, cur_total} + {1'b0, amount};
      dec.new_total = sum[etp_pkg::TIME_W] ? etp_pkg::TOTAL_MAX
                                           : sum[etp_pkg::TIME_W-1:0];
   end

   always_comb begin
      rsp                 = '0;
      rsp.error_code      = err;
      if (dec.credit) begin
         rsp.credited_valid  = 1'b1;
         rsp.credited_func   = top_id;
         rsp.credited_amount = amount;
         rsp.new_total       = dec.new_total;
      end
   end

endmodule

[rtl/exclusive_time_profiler.sv]
// ----------------------------------------------------------------------------
// exclusive_time_profiler: exclusive time per function from a trace stream
// start and end events drive a call stack; time is credited to the running
// function and summed, saturating, in a per-function table
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake              word
//   req       in          req_valid / req_stall  kind, func_id, timestamp
//   rsp       out         rsp_valid / rsp_stall  credit, total, depth, error
//
// one event per cycle sustained unless req_stall; each result appears in the
// cycle after its event is taken, held in the output register while stalled
// after reset the total table is swept to zero with req_stall high; the stack
// needs no clearing
// req_stall is high while the output register holds a stalled word, so a new
// event is still taken in the cycle the old result leaves
// the rate is set by the loop through stack count, last time and the table
// read-modify-write; the next top and its total are prefetched each cycle
//
module exclusive_time_profiler #(
   parameter int NUM_FUNCS   = 256,
   parameter int STACK_DEPTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  etp_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output etp_pkg::rsp_word_type rsp_word
);

   localparam int CW = $clog2(STACK_DEPTH + 1);

   // stack and table interface
   etp_pkg::stack_op_type      ops;
   etp_pkg::stack_status_type  status;
   logic [etp_pkg::ID_W-1:0]   top_id;
   logic [etp_pkg::ID_W-1:0]   top_next;
   logic [CW-1:0]              depth_next;
   logic [etp_pkg::TIME_W-1:0] cur_total;
   logic                       clearing;

   // event evaluation
   etp_pkg::decision_type      dec;
   etp_pkg::rsp_word_type      eval_rsp;

   // handshake and state
   logic                       accept;
   logic [etp_pkg::LAST_W-1:0] last_ff, last_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   etp_pkg::rsp_word_type      rsp_ff, rsp_in;

   // stalled result blocks new words; the table sweep blocks everything
   assign req_stall = clearing || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   // state changes only for an accepted word without an error
   assign ops.push = accept && dec.push;
   assign ops.pop  = accept && dec.pop;

   etp_stack #(
      .STACK_DEPTH(STACK_DEPTH)
   ) u_stack (
      .clock     (clock),
      .reset     (reset),
      .ops       (ops),
      .push_id   (req_word.func_id),
      .status    (status),
      .top_id    (top_id),
      .top_next  (top_next),
      .depth_next(depth_next)
   );

   // the credited function is always the current top
   etp_totals #(
      .NUM_FUNCS(NUM_FUNCS)
   ) u_totals (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept && dec.credit),
      .wr_id   (top_id),
      .wr_data (dec.new_total),
      .rd_id   (top_next),
      .rd_total(cur_total),
      .clearing(clearing)
   );

   etp_eval u_eval (
      .req      (req_word),
      .status   (status),
      .top_id   (top_id),
      .cur_total(cur_total),
      .last_time(last_ff),
      .dec      (dec),
      .rsp      (eval_rsp)
   );

   // last credited time, one bit wider so an end at the top of time is kept
   always_comb begin
      last_in = last_ff;
      if (ops.push || ops.pop) begin
         last_in = dec.new_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= '0;
      end else begin
         last_ff <= last_in;
      end
   end

   // output register
   always_comb begin
      rsp_in             = eval_rsp;
      rsp_in.depth_after = etp_pkg::DEPTH_W'(depth_next);
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

[rtl/etp_checker.sv]
// ----------------------------------------------------------------------------
// etp_checker: port-level checks of the exclusive time profiler
// result timing, stall coupling between the channels, result hold
// ----------------------------------------------------------------------------
module etp_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input etp_pkg::rsp_word_type rsp_word
);

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_word_yields_result : assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("taken word gave no result in the next cycle");

   a_no_overtake : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("word taken while a stalled result waits");

   a_result_held : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled result changed or vanished");

endmodule

bind exclusive_time_profiler etp_checker u_etp_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_word (rsp_word)
);
